/* hw/rtl/mcmc_pkg.sv */
// Shared constants, types and codes for the matrix chain cost block.
`default_nettype none
package mcmc_pkg;

    localparam int MAX_MATRICES = 32;
    localparam int DIM_BITS     = 16;

    localparam int DIM_DEPTH    = MAX_MATRICES + 1;
    localparam int DIM_IDX_W    = $clog2(DIM_DEPTH);
    localparam int DCNT_W       = $clog2(DIM_DEPTH + 1);
    localparam int DIMS_ADDR_W  = DIM_IDX_W + 1;
    localparam int DIMS_DEPTH   = 2 ** DIMS_ADDR_W;

    localparam int MAT_IDX_W    = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
    localparam int COST_ADDR_W  = 2 * MAT_IDX_W;
    localparam int COST_DEPTH   = 2 ** COST_ADDR_W;

    localparam int COST_W       = 64;
    localparam int PROD1_W      = 2 * DIM_BITS;
    localparam int PROD2_W      = 3 * DIM_BITS;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FEW  = 2'd1;
    localparam logic [1:0] ST_MANY = 2'd2;
    localparam logic [1:0] ST_SAT  = 2'd3;

    typedef logic [DIM_BITS-1:0] dim_t;
    typedef logic [COST_W-1:0]   cost_t;

    typedef struct packed {
        logic              bank;
        logic [1:0]        status;
        logic [DCNT_W-1:0] nmat;
    } job_t;

endpackage
`default_nettype wire

/* hw/rtl/mcmc_ram.sv */
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none
module mcmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule
`default_nettype wire

/* hw/rtl/mcmc_front.sv */
// Front end: takes dimension words, stores them in a bank and queues one job per chain.
`default_nettype none
module mcmc_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             dim_valid,
    output logic                                  dim_ready,
    input  wire logic [15:0]                      dim_value,
    input  wire logic                             is_last,
    input  wire logic                             q_full,
    output logic                                  push,
    output mcmc_pkg::job_t                        push_job,
    output logic                                  dims_we,
    output logic      [mcmc_pkg::DIMS_ADDR_W-1:0] dims_waddr,
    output mcmc_pkg::dim_t                        dims_wdata
);

    logic [mcmc_pkg::DCNT_W-1:0] count_reg, count_next;
    logic                        many_reg, many_next;
    logic                        bank_reg, bank_next;
    logic                        accept;
    logic                        store_full;
    logic [mcmc_pkg::DCNT_W-1:0] count_after;

    assign dim_ready   = !q_full;
    assign accept      = dim_valid && dim_ready;
    assign store_full  = (count_reg >= mcmc_pkg::DCNT_W'(mcmc_pkg::DIM_DEPTH));
    assign count_after = store_full ? count_reg : count_reg + mcmc_pkg::DCNT_W'(1);

    assign dims_we    = accept && !store_full;
    assign dims_waddr = {bank_reg, count_reg[mcmc_pkg::DIM_IDX_W-1:0]};
    assign dims_wdata = mcmc_pkg::dim_t'(dim_value);

    assign push = accept && is_last;

    always_comb
    begin
        push_job.bank = bank_reg;
        push_job.nmat = count_after - mcmc_pkg::DCNT_W'(1);
        if (many_reg || store_full)
        begin
            push_job.status = mcmc_pkg::ST_MANY;
        end
        else if (count_after < mcmc_pkg::DCNT_W'(2))
        begin
            push_job.status = mcmc_pkg::ST_FEW;
        end
        else
        begin
            push_job.status = mcmc_pkg::ST_OK;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        many_next  = many_reg;
        bank_next  = bank_reg;
        if (accept)
        begin
            if (is_last)
            begin
                count_next = '0;
                many_next  = 1'b0;
                bank_next  = !bank_reg;
            end
            else
            begin
                count_next = count_after;
                many_next  = many_reg || store_full;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            many_reg  <= 1'b0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            many_reg  <= many_next;
            bank_reg  <= bank_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/mcmc_queue.sv */
// Two-entry job queue between the front end and the table engine.
`default_nettype none
module mcmc_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire mcmc_pkg::job_t push_job,
    input  wire logic           pop,
    output logic                q_full,
    output logic                head_valid,
    output mcmc_pkg::job_t      head_job
);

    mcmc_pkg::job_t q_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     cnt_reg, cnt_next;

    assign q_full     = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_job   = q_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/mcmc_back.sv */
// Table engine: fills the cost table by chain length and emits the whole-chain cost.
`default_nettype none
module mcmc_back (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             head_valid,
    input  wire mcmc_pkg::job_t                   head_job,
    output logic                                  pop,
    output logic      [mcmc_pkg::DIMS_ADDR_W-1:0] dims_raddr_a,
    output logic      [mcmc_pkg::DIMS_ADDR_W-1:0] dims_raddr_b,
    input  wire mcmc_pkg::dim_t                   dims_rdata_a,
    input  wire mcmc_pkg::dim_t                   dims_rdata_b,
    output logic                                  cost_valid,
    input  wire logic                             cost_ready,
    output logic      [63:0]                      min_cost,
    output logic      [1:0]                       status
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_CELL = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CAP  = 3'd3;
    localparam logic [2:0] S_MUL1 = 3'd4;
    localparam logic [2:0] S_MUL2 = 3'd5;
    localparam logic [2:0] S_ACC  = 3'd6;
    localparam logic [2:0] S_DONE = 3'd7;

    function automatic mcmc_pkg::cost_t sat_add(mcmc_pkg::cost_t a, mcmc_pkg::cost_t b);
        logic [mcmc_pkg::COST_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[mcmc_pkg::COST_W] ? '1 : s[mcmc_pkg::COST_W-1:0];
    endfunction

    logic [2:0]                       state_reg, state_next;
    logic [mcmc_pkg::MAT_IDX_W-1:0]   i_reg, i_next;
    logic [mcmc_pkg::MAT_IDX_W-1:0]   k_reg, k_next;
    logic [mcmc_pkg::MAT_IDX_W-1:0]   j_reg, j_next;
    logic [mcmc_pkg::DCNT_W-1:0]      len_reg, len_next;
    logic                             out_valid_reg, out_valid_next;

    mcmc_pkg::cost_t                  best_reg, best_next;
    mcmc_pkg::cost_t                  ab_reg, ab_next;
    mcmc_pkg::cost_t                  res_cost_reg, res_cost_next;
    logic [1:0]                       res_status_reg, res_status_next;
    mcmc_pkg::dim_t                   di_reg, di_next;
    mcmc_pkg::dim_t                   dk_reg, dk_next;
    mcmc_pkg::dim_t                   dj_reg, dj_next;
    logic [mcmc_pkg::PROD1_W-1:0]     p1_reg, p1_next;
    logic [mcmc_pkg::PROD2_W-1:0]     p2_reg, p2_next;
    logic                             diag_a_reg, diag_a_next;
    logic                             diag_b_reg, diag_b_next;
    mcmc_pkg::cost_t                  out_cost_reg, out_cost_next;
    logic [1:0]                       out_status_reg, out_status_next;

    logic                             cost_we;
    logic [mcmc_pkg::COST_ADDR_W-1:0] cost_waddr;
    logic [mcmc_pkg::COST_ADDR_W-1:0] cost_raddr_a;
    logic [mcmc_pkg::COST_ADDR_W-1:0] cost_raddr_b;
    mcmc_pkg::cost_t                  cost_rdata_a;
    mcmc_pkg::cost_t                  cost_rdata_b;

    logic [mcmc_pkg::MAT_IDX_W-1:0]   k1_m;
    logic [mcmc_pkg::DIM_IDX_W-1:0]   k1_d;
    logic [mcmc_pkg::DIM_IDX_W-1:0]   j1_d;
    mcmc_pkg::cost_t                  ca;
    mcmc_pkg::cost_t                  cb;
    mcmc_pkg::cost_t                  ab_sum;
    mcmc_pkg::cost_t                  q;
    mcmc_pkg::cost_t                  qmin;
    logic [1:0]                       final_status;

    mcmc_ram #(
        .WIDTH (mcmc_pkg::COST_W),
        .DEPTH (mcmc_pkg::COST_DEPTH)
    ) u_cost_ram (
        .clk     (clk),
        .we      (cost_we),
        .waddr   (cost_waddr),
        .wdata   (qmin),
        .raddr_a (cost_raddr_a),
        .raddr_b (cost_raddr_b),
        .rdata_a (cost_rdata_a),
        .rdata_b (cost_rdata_b)
    );

    assign k1_m = k_reg + mcmc_pkg::MAT_IDX_W'(1);
    assign k1_d = mcmc_pkg::DIM_IDX_W'(k_reg) + mcmc_pkg::DIM_IDX_W'(1);
    assign j1_d = mcmc_pkg::DIM_IDX_W'(j_reg) + mcmc_pkg::DIM_IDX_W'(1);

    assign dims_raddr_a = (state_reg == S_CAP) ? {head_job.bank, j1_d}
                                               : {head_job.bank, mcmc_pkg::DIM_IDX_W'(i_reg)};
    assign dims_raddr_b = {head_job.bank, k1_d};
    assign cost_raddr_a = {i_reg, k_reg};
    assign cost_raddr_b = {k1_m, j_reg};
    assign cost_waddr   = {i_reg, j_reg};

    // diagonal cells cost nothing and are never stored
    assign ca     = diag_a_reg ? '0 : cost_rdata_a;
    assign cb     = diag_b_reg ? '0 : cost_rdata_b;
    assign ab_sum = sat_add(ca, cb);
    assign q      = sat_add(ab_reg, mcmc_pkg::COST_W'(p2_reg));
    assign qmin   = (q < best_reg) ? q : best_reg;

    assign final_status = (res_status_reg == mcmc_pkg::ST_OK && res_cost_reg == '1)
                          ? mcmc_pkg::ST_SAT : res_status_reg;

    assign cost_valid = out_valid_reg;
    assign min_cost   = out_cost_reg;
    assign status     = out_status_reg;

    always_comb
    begin
        state_next      = state_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        j_next          = j_reg;
        len_next        = len_reg;
        best_next       = best_reg;
        ab_next         = ab_reg;
        res_cost_next   = res_cost_reg;
        res_status_next = res_status_reg;
        di_next         = di_reg;
        dk_next         = dk_reg;
        dj_next         = dj_reg;
        p1_next         = p1_reg;
        p2_next         = p2_reg;
        diag_a_next     = diag_a_reg;
        diag_b_next     = diag_b_reg;
        out_cost_next   = out_cost_reg;
        out_status_next = out_status_reg;
        out_valid_next  = out_valid_reg && !cost_ready;
        cost_we         = 1'b0;
        pop             = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (head_valid)
                begin
                    if (head_job.status != mcmc_pkg::ST_OK ||
                        head_job.nmat == mcmc_pkg::DCNT_W'(1))
                    begin
                        res_cost_next   = '0;
                        res_status_next = head_job.status;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        len_next   = mcmc_pkg::DCNT_W'(2);
                        i_next     = '0;
                        state_next = S_CELL;
                    end
                end
            end
            S_CELL:
            begin
                j_next     = mcmc_pkg::MAT_IDX_W'(mcmc_pkg::DCNT_W'(i_reg) + len_reg
                                                  - mcmc_pkg::DCNT_W'(1));
                k_next     = i_reg;
                best_next  = '1;
                state_next = S_RD;
            end
            S_RD:
            begin
                diag_a_next = (k_reg == i_reg);
                diag_b_next = (k1_m == j_reg);
                state_next  = S_CAP;
            end
            S_CAP:
            begin
                di_next    = dims_rdata_a;
                dk_next    = dims_rdata_b;
                ab_next    = ab_sum;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                p1_next    = mcmc_pkg::PROD1_W'(di_reg) * mcmc_pkg::PROD1_W'(dk_reg);
                dj_next    = dims_rdata_a;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                p2_next    = mcmc_pkg::PROD2_W'(p1_reg) * mcmc_pkg::PROD2_W'(dj_reg);
                state_next = S_ACC;
            end
            S_ACC:
            begin
                best_next = qmin;
                if (k1_m == j_reg)
                begin
                    cost_we         = 1'b1;
                    res_cost_next   = qmin;
                    res_status_next = mcmc_pkg::ST_OK;
                    if (mcmc_pkg::DCNT_W'(i_reg) + len_reg < head_job.nmat)
                    begin
                        i_next     = i_reg + mcmc_pkg::MAT_IDX_W'(1);
                        state_next = S_CELL;
                    end
                    else if (len_reg == head_job.nmat)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        len_next   = len_reg + mcmc_pkg::DCNT_W'(1);
                        i_next     = '0;
                        state_next = S_CELL;
                    end
                end
                else
                begin
                    k_next     = k1_m;
                    state_next = S_RD;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || cost_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_cost_next   = res_cost_reg;
                    out_status_next = final_status;
                    pop             = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        i_reg          <= i_next;
        k_reg          <= k_next;
        j_reg          <= j_next;
        len_reg        <= len_next;
        best_reg       <= best_next;
        ab_reg         <= ab_next;
        res_cost_reg   <= res_cost_next;
        res_status_reg <= res_status_next;
        di_reg         <= di_next;
        dk_reg         <= dk_next;
        dj_reg         <= dj_next;
        p1_reg         <= p1_next;
        p2_reg         <= p2_next;
        diag_a_reg     <= diag_a_next;
        diag_b_reg     <= diag_b_next;
        out_cost_reg   <= out_cost_next;
        out_status_reg <= out_status_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule
`default_nettype wire

/* hw/rtl/matrix_chain_min_cost_top.sv */
// Top level of the matrix chain minimum cost block.
// Dimension words are taken one per cycle while fewer than two chains wait in the job queue.
// For a chain of n matrices the result follows the last word once every split point of every
// table cell has passed through the read, capture, multiply and accumulate states in turn.
// Chains with a dimension-count error or a single matrix skip the table and go to done.
// Reset clears control state only; the dimension and cost stores need no clearing pass.
`default_nettype none
module matrix_chain_min_cost_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        dim_valid,
    output logic             dim_ready,
    input  wire logic [15:0] dim_value,
    input  wire logic        is_last,
    output logic             cost_valid,
    input  wire logic        cost_ready,
    output logic      [63:0] min_cost,
    output logic      [1:0]  status
);

    logic                             q_full;
    logic                             push;
    mcmc_pkg::job_t                   push_job;
    logic                             pop;
    logic                             head_valid;
    mcmc_pkg::job_t                   head_job;
    logic                             dims_we;
    logic [mcmc_pkg::DIMS_ADDR_W-1:0] dims_waddr;
    mcmc_pkg::dim_t                   dims_wdata;
    logic [mcmc_pkg::DIMS_ADDR_W-1:0] dims_raddr_a;
    logic [mcmc_pkg::DIMS_ADDR_W-1:0] dims_raddr_b;
    mcmc_pkg::dim_t                   dims_rdata_a;
    mcmc_pkg::dim_t                   dims_rdata_b;

    mcmc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .dim_valid  (dim_valid),
        .dim_ready  (dim_ready),
        .dim_value  (dim_value),
        .is_last    (is_last),
        .q_full     (q_full),
        .push       (push),
        .push_job   (push_job),
        .dims_we    (dims_we),
        .dims_waddr (dims_waddr),
        .dims_wdata (dims_wdata)
    );

    mcmc_ram #(
        .WIDTH (mcmc_pkg::DIM_BITS),
        .DEPTH (mcmc_pkg::DIMS_DEPTH)
    ) u_dims_ram (
        .clk     (clk),
        .we      (dims_we),
        .waddr   (dims_waddr),
        .wdata   (dims_wdata),
        .raddr_a (dims_raddr_a),
        .raddr_b (dims_raddr_b),
        .rdata_a (dims_rdata_a),
        .rdata_b (dims_rdata_b)
    );

    mcmc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .q_full     (q_full),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    mcmc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head_job     (head_job),
        .pop          (pop),
        .dims_raddr_a (dims_raddr_a),
        .dims_raddr_b (dims_raddr_b),
        .dims_rdata_a (dims_rdata_a),
        .dims_rdata_b (dims_rdata_b),
        .cost_valid   (cost_valid),
        .cost_ready   (cost_ready),
        .min_cost     (min_cost),
        .status       (status)
    );

`ifndef NO_ASSERTIONS
    a_sat_cost : assert property (@(posedge clk) disable iff (!rst_n)
        cost_valid && status == mcmc_pkg::ST_SAT |-> min_cost == '1)
        else $error("saturated status without saturated cost");

    a_err_zero : assert property (@(posedge clk) disable iff (!rst_n)
        cost_valid && (status == mcmc_pkg::ST_FEW || status == mcmc_pkg::ST_MANY)
        |-> min_cost == '0)
        else $error("error status with non-zero cost");

    a_job_queued : assert property (@(posedge clk) disable iff (!rst_n)
        dim_valid && dim_ready && is_last |=> head_valid)
        else $error("closing word left no job in the queue");

    a_pop_valid : assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("job queue popped while empty");
`endif

endmodule
`default_nettype wire
